// ----- design/bptc_pkg.sv -----
// Shared types, constants and helpers for the barometric compensation block.
// Holds the microcode word layout and the control store used by the sequencer.
// No dependencies.
`default_nettype none

package bptc_pkg;

  localparam int unsigned NUM_COEF  = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned RAW_W     = 24;
  localparam int unsigned DT_W      = 26;
  localparam int unsigned MA_W      = 26;
  localparam int unsigned MB_W      = 18;
  localparam int unsigned PROD_W    = MA_W + MB_W;
  localparam int unsigned OFF_W     = 36;
  localparam int unsigned SENS_W    = 35;
  localparam int unsigned ACC_W     = 60;
  localparam int unsigned TEMP_W    = 19;
  localparam int unsigned PRES_W    = 22;
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned SENS_LO_W = 17;
  localparam int          TEMP_BASE = 2000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS    = 3'd0,
    REG_OFF     = 3'd1,
    REG_SENS_TC = 3'd2,
    REG_OFF_TC  = 3'd3,
    REG_TREF    = 3'd4,
    REG_TSENS   = 3'd5
  } reg_idx_t;

  typedef enum logic [0:0] {
    KIND_TEMP = 1'b0,
    KIND_PRES = 1'b1
  } kind_t;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] off;
    logic [COEF_W-1:0] sens_tc;
    logic [COEF_W-1:0] off_tc;
    logic [COEF_W-1:0] tref;
    logic [COEF_W-1:0] tsens;
  } coef_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [0:0] {
    MA_DT,
    MA_RAW
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_TSENS,
    MB_OFF_TC,
    MB_SENS_TC,
    MB_SENS_LO,
    MB_SENS_HI
  } mul_b_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD_DT,
    OP_TEMP,
    OP_OFF,
    OP_SENS,
    OP_ACC_LOAD,
    OP_ACC_ADD,
    OP_ACC_DIV,
    OP_ACC_SUB,
    OP_PRES
  } alu_op_t;

  typedef enum logic [0:0] {
    JMP_NONE,
    JMP_IF_PRES
  } jmp_t;

  typedef struct packed {
    mul_a_t  ma;
    mul_b_t  mb;
    logic    mul_en;
    alu_op_t op;
    jmp_t    jmp;
    step_t   target;
    logic    last;
  } ucode_t;

  typedef struct packed {
    logic   exec;
    ucode_t uc;
  } seq_ctl_t;

  localparam step_t STEP_PRES = 4'd4;

  function automatic ucode_t mk_uc(input mul_a_t ma, input mul_b_t mb, input logic mul_en,
                                   input alu_op_t op, input jmp_t jmp, input step_t target,
                                   input logic last);
    ucode_t w;
    w.ma     = ma;
    w.mb     = mb;
    w.mul_en = mul_en;
    w.op     = op;
    w.jmp    = jmp;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  // Control store. Temperature runs steps 0-3, pressure step 0 and then 4-12.
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      4'd0:    w = mk_uc(MA_DT,  MB_TSENS,   1'b0, OP_NOP,      JMP_IF_PRES, STEP_PRES, 1'b0);
      4'd1:    w = mk_uc(MA_DT,  MB_TSENS,   1'b0, OP_LOAD_DT,  JMP_NONE,    '0,        1'b0);
      4'd2:    w = mk_uc(MA_DT,  MB_TSENS,   1'b1, OP_NOP,      JMP_NONE,    '0,        1'b0);
      4'd3:    w = mk_uc(MA_DT,  MB_TSENS,   1'b0, OP_TEMP,     JMP_NONE,    '0,        1'b1);
      4'd4:    w = mk_uc(MA_DT,  MB_OFF_TC,  1'b1, OP_NOP,      JMP_NONE,    '0,        1'b0);
      4'd5:    w = mk_uc(MA_DT,  MB_SENS_TC, 1'b1, OP_OFF,      JMP_NONE,    '0,        1'b0);
      4'd6:    w = mk_uc(MA_DT,  MB_TSENS,   1'b0, OP_SENS,     JMP_NONE,    '0,        1'b0);
      4'd7:    w = mk_uc(MA_RAW, MB_SENS_LO, 1'b1, OP_NOP,      JMP_NONE,    '0,        1'b0);
      4'd8:    w = mk_uc(MA_RAW, MB_SENS_HI, 1'b1, OP_ACC_LOAD, JMP_NONE,    '0,        1'b0);
      4'd9:    w = mk_uc(MA_DT,  MB_TSENS,   1'b0, OP_ACC_ADD,  JMP_NONE,    '0,        1'b0);
      4'd10:   w = mk_uc(MA_DT,  MB_TSENS,   1'b0, OP_ACC_DIV,  JMP_NONE,    '0,        1'b0);
      4'd11:   w = mk_uc(MA_DT,  MB_TSENS,   1'b0, OP_ACC_SUB,  JMP_NONE,    '0,        1'b0);
      4'd12:   w = mk_uc(MA_DT,  MB_TSENS,   1'b0, OP_PRES,     JMP_NONE,    '0,        1'b1);
      default: w = mk_uc(MA_DT,  MB_TSENS,   1'b0, OP_NOP,      JMP_NONE,    '0,        1'b1);
    endcase
    return w;
  endfunction

  // Signed division by 2^k that truncates toward zero.
  function automatic logic signed [ACC_W-1:0] div_pow2(input logic signed [ACC_W-1:0] x,
                                                       input int unsigned k);
    logic signed [ACC_W-1:0] bias;
    bias = x[ACC_W-1] ? ((ACC_W'(1) << k) - ACC_W'(1)) : '0;
    return (x + bias) >>> k;
  endfunction

endpackage

`default_nettype wire

// ----- design/bptc_seq.sv -----
// Microcode sequencer: step counter, busy flag and control store lookup.
// Depends on bptc_pkg for the control word layout and the program.
`default_nettype none

module bptc_seq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               is_pressure,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  output bptc_pkg::seq_ctl_t      ctl
);

  logic              busy;
  logic              busy_next;
  bptc_pkg::step_t   step;
  bptc_pkg::step_t   step_next;
  bptc_pkg::ucode_t  uc;
  logic              hold;
  logic              exec;
  logic              take;

  assign uc       = bptc_pkg::ucode_rom(step);
  // The final step waits while the previous result is still pending.
  assign hold     = uc.last && out_valid && !out_ready;
  assign exec     = busy && !hold;
  assign in_ready = !busy;
  assign take     = in_valid && in_ready;

  assign ctl.exec = exec;
  assign ctl.uc   = uc;

  always_comb begin
    busy_next = busy;
    step_next = step;
    if (take) begin
      busy_next = 1'b1;
      step_next = '0;
    end else if (exec) begin
      if (uc.last) begin
        busy_next = 1'b0;
      end else if (uc.jmp == bptc_pkg::JMP_IF_PRES && is_pressure) begin
        step_next = uc.target;
      end else begin
        step_next = step + bptc_pkg::step_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/bptc_datapath.sv -----
// Datapath: request latch, shared 26x18 multiplier, accumulator and result registers.
// Depends on bptc_pkg; driven by the control word from bptc_seq.
`default_nettype none

module bptc_datapath (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic                                   action_in,
  input  wire logic [bptc_pkg::RAW_W-1:0]             raw_in,
  input  wire bptc_pkg::coef_t                        coef,
  input  wire bptc_pkg::seq_ctl_t                     ctl,
  output logic                                        is_pressure,
  output logic                                        result_kind,
  output logic signed [bptc_pkg::TEMP_W-1:0]          temperature,
  output logic signed [bptc_pkg::PRES_W-1:0]          pressure
);

  localparam int unsigned AW = bptc_pkg::ACC_W;

  logic                                 act;
  logic [bptc_pkg::RAW_W-1:0]           raw;
  logic signed [bptc_pkg::DT_W-1:0]     dt;
  logic signed [bptc_pkg::DT_W-1:0]     dt_next;
  logic signed [bptc_pkg::MA_W-1:0]     ma;
  logic signed [bptc_pkg::MB_W-1:0]     mb;
  logic signed [bptc_pkg::PROD_W-1:0]   prod;
  logic signed [bptc_pkg::PROD_W-1:0]   mul_out;
  logic signed [bptc_pkg::OFF_W-1:0]    off;
  logic signed [bptc_pkg::SENS_W-1:0]   sens;
  logic signed [AW-1:0]                 acc;
  logic signed [AW-1:0]                 prod_x;
  logic signed [AW-1:0]                 off_x;
  logic signed [AW-1:0]                 c1_x;
  logic signed [AW-1:0]                 c2_x;
  logic signed [AW-1:0]                 temp_x;
  logic signed [AW-1:0]                 pres_x;
  logic                                 exec;

  assign exec        = ctl.exec;
  assign is_pressure = act;

  assign dt_next = bptc_pkg::DT_W'({2'b00, raw}) - bptc_pkg::DT_W'({2'b00, coef.tref, 8'h00});

  assign prod_x = {{(AW - bptc_pkg::PROD_W){prod[bptc_pkg::PROD_W-1]}}, prod};
  assign off_x  = {{(AW - bptc_pkg::OFF_W){off[bptc_pkg::OFF_W-1]}}, off};
  assign c1_x   = {{(AW - bptc_pkg::COEF_W - 15){1'b0}}, coef.sens, 15'h0000};
  assign c2_x   = {{(AW - bptc_pkg::COEF_W - 16){1'b0}}, coef.off, 16'h0000};

  assign temp_x = bptc_pkg::div_pow2(prod_x, 23) + AW'(bptc_pkg::TEMP_BASE);
  assign pres_x = bptc_pkg::div_pow2(acc, 15);

  always_comb begin
    case (ctl.uc.ma)
      bptc_pkg::MA_RAW: ma = {2'b00, raw};
      default:          ma = dt;
    endcase
  end

  // SENS is split into an unsigned low part and a signed high part for the two products.
  always_comb begin
    case (ctl.uc.mb)
      bptc_pkg::MB_TSENS:   mb = {2'b00, coef.tsens};
      bptc_pkg::MB_OFF_TC:  mb = {2'b00, coef.off_tc};
      bptc_pkg::MB_SENS_TC: mb = {2'b00, coef.sens_tc};
      bptc_pkg::MB_SENS_LO: mb = {1'b0, sens[bptc_pkg::SENS_LO_W-1:0]};
      bptc_pkg::MB_SENS_HI: mb = sens[bptc_pkg::SENS_W-1:bptc_pkg::SENS_LO_W];
      default:              mb = '0;
    endcase
  end

  assign mul_out = ma * mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      dt <= '0;
    end else if (exec && ctl.uc.op == bptc_pkg::OP_LOAD_DT) begin
      dt <= dt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      act <= action_in;
      raw <= raw_in;
    end
    if (exec && ctl.uc.mul_en) begin
      prod <= mul_out;
    end
    if (exec) begin
      case (ctl.uc.op)
        bptc_pkg::OP_OFF: begin
          off <= bptc_pkg::OFF_W'(c2_x + bptc_pkg::div_pow2(prod_x, 7));
        end
        bptc_pkg::OP_SENS: begin
          sens <= bptc_pkg::SENS_W'(c1_x + bptc_pkg::div_pow2(prod_x, 8));
        end
        bptc_pkg::OP_ACC_LOAD: begin
          acc <= prod_x;
        end
        bptc_pkg::OP_ACC_ADD: begin
          acc <= acc + (prod_x <<< bptc_pkg::SENS_LO_W);
        end
        bptc_pkg::OP_ACC_DIV: begin
          acc <= bptc_pkg::div_pow2(acc, 21);
        end
        bptc_pkg::OP_ACC_SUB: begin
          acc <= acc - off_x;
        end
        bptc_pkg::OP_TEMP: begin
          result_kind <= act;
          temperature <= bptc_pkg::TEMP_W'(temp_x);
          pressure    <= '0;
        end
        bptc_pkg::OP_PRES: begin
          result_kind <= act;
          temperature <= '0;
          pressure    <= bptc_pkg::PRES_W'(pres_x);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/baro_pressure_temp_compensation.sv -----
// Barometric sensor first-order compensation, top level.
// Uses bptc_pkg, bptc_seq and bptc_datapath.
//
// Usage: a request on the input channel (in_valid/in_ready) carries one raw
// conversion, tagged by action as temperature (0) or pressure (1). Every request
// yields exactly one result on the output channel (out_valid/out_ready):
// result_kind echoes action, and the field that does not apply reads zero.
// A temperature request also keeps its dT, which later pressure requests use.
// Calibration words are written through cfg_write/cfg_index/cfg_data while idle;
// an index beyond the six registers is ignored.
// Timing: a temperature request runs a four-step program and a pressure request
// a ten-step program on one shared 26x18 multiplier; the result is registered
// when the last step executes, and a new request can be taken the cycle after
// the program ends.
// The result sits in an output register, so the next request is accepted and
// runs while it waits; if the receiver still stalls when the next program
// reaches its last step, the sequencer holds on that step.
// Reset (synchronous, active high) clears the calibration words, the kept dT
// and all handshake state.
`default_nettype none

module baro_pressure_temp_compensation (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   action,
  input  wire logic [bptc_pkg::RAW_W-1:0]             raw_value,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic                                        result_kind,
  output logic signed [bptc_pkg::TEMP_W-1:0]          temperature,
  output logic signed [bptc_pkg::PRES_W-1:0]          pressure,
  input  wire logic                                   cfg_write,
  input  wire logic [bptc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [bptc_pkg::COEF_W-1:0]            cfg_data
);

  bptc_pkg::coef_t     coef;
  bptc_pkg::seq_ctl_t  ctl;
  logic                is_pressure;
  logic                start;
  logic                done;
  logic                out_valid_next;

  assign start = in_valid && in_ready;
  assign done  = ctl.exec && ctl.uc.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        bptc_pkg::REG_SENS:    coef.sens    <= cfg_data;
        bptc_pkg::REG_OFF:     coef.off     <= cfg_data;
        bptc_pkg::REG_SENS_TC: coef.sens_tc <= cfg_data;
        bptc_pkg::REG_OFF_TC:  coef.off_tc  <= cfg_data;
        bptc_pkg::REG_TREF:    coef.tref    <= cfg_data;
        bptc_pkg::REG_TSENS:   coef.tsens   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_next = done || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  bptc_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .is_pressure (is_pressure),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ctl         (ctl)
  );

  bptc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .action_in   (action),
    .raw_in      (raw_value),
    .coef        (coef),
    .ctl         (ctl),
    .is_pressure (is_pressure),
    .result_kind (result_kind),
    .temperature (temperature),
    .pressure    (pressure)
  );

  // A finishing program must never overwrite a result that is still pending.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    done |-> (!out_valid || out_ready))
    else $error("result register overwritten while pending");

  // A finished program presents its result in the next cycle.
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    done |=> out_valid)
    else $error("finished program did not raise out_valid");

  // Once a request is taken, the block is busy until its program ends.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ready)
    else $error("input still ready after accepting a request");

  // The unused result field of a temperature result reads zero.
  a_temp_zero_pres: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == bptc_pkg::KIND_TEMP) |-> (pressure == '0))
    else $error("temperature result carries a nonzero pressure");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking bench for the barometric compensation block: directed and random
// conversions with randomly paced requests and results, checked against a predictor.
// Depends on bptc_pkg and baro_pressure_temp_compensation.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bptc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam logic [RAW_W-1:0]     RAW_MAX      = {RAW_W{1'b1}};
  localparam int                   IDLE_LIMIT   = 5000;
  localparam int                   ITEMS_PER_PHASE = 75;

  typedef struct {
    kind_t                    kind;
    logic signed [TEMP_W-1:0] temp;
    logic signed [PRES_W-1:0] pres;
  } reading_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     action = 1'b0;
  logic [RAW_W-1:0]         raw_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     result_kind;
  logic signed [TEMP_W-1:0] temperature;
  logic signed [PRES_W-1:0] pressure;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [COEF_W-1:0]        cfg_data = '0;

  // Predictor state: calibration words and the last temperature delta.
  coef_t                  cal;
  logic signed [DT_W-1:0] kept_dt;
  reading_t               pending_readings[$];
  int                     mismatches = 0;
  bit                     sender_steady = 1'b0;
  bit                     receiver_steady = 1'b0;
  int                     stall_left = 0;
  int                     idle_cycles = 0;

  baro_pressure_temp_compensation u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .raw_value   (raw_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .temperature (temperature),
    .pressure    (pressure),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #1 clk = ~clk;

  // Mostly no pause, some short ones and a few long ones.
  function automatic int pick_pause();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic void load_cal(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [COEF_W-1:0] data);
    case (idx)
      REG_SENS:    cal.sens    = data;
      REG_OFF:     cal.off     = data;
      REG_SENS_TC: cal.sens_tc = data;
      REG_OFF_TC:  cal.off_tc  = data;
      REG_TREF:    cal.tref    = data;
      REG_TSENS:   cal.tsens   = data;
      default:     ;
    endcase
  endfunction

  // First-order compensation; a temperature request also refreshes the kept delta.
  function automatic reading_t compensate_reading(input kind_t kind,
                                                  input logic [RAW_W-1:0] raw);
    reading_t r;
    longint   raw_l, dt, off, sens, full;
    longint   c1, c2, c3, c4, c5, c6;
    raw_l = raw;
    c1 = cal.sens;
    c2 = cal.off;
    c3 = cal.sens_tc;
    c4 = cal.off_tc;
    c5 = cal.tref;
    c6 = cal.tsens;
    r.kind = kind;
    r.temp = '0;
    r.pres = '0;
    if (kind == KIND_TEMP) begin
      dt = raw_l - c5 * 256;
      kept_dt = dt[DT_W-1:0];
      full = 2000 + (dt * c6) / 8388608;
      r.temp = full[TEMP_W-1:0];
    end else begin
      dt = kept_dt;
      off = c2 * 65536 + (c4 * dt) / 128;
      sens = c1 * 32768 + (c3 * dt) / 256;
      full = ((raw_l * sens) / 2097152 - off) / 32768;
      r.pres = full[PRES_W-1:0];
    end
    return r;
  endfunction

  // Sends one conversion request and records its expected reading on acceptance.
  task automatic send_conversion(input kind_t kind, input logic [RAW_W-1:0] raw);
    int gap;
    gap = sender_steady ? 0 : pick_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= kind;
    raw_value <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_readings.push_back(compensate_reading(kind, raw));
  endtask

  // Lets every outstanding reading arrive so the registers can be touched safely.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_cal(input coef_t c);
    logic [COEF_W-1:0] words [NUM_COEF];
    words = '{c.sens, c.off, c.sens_tc, c.off_tc, c.tref, c.tsens};
    for (int i = 0; i < NUM_COEF; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= words[i];
      @(posedge clk);
      load_cal(CFG_IDX_W'(i), words[i]);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_spare(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    load_cal(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic coef_t rand_cal();
    coef_t c;
    logic [COEF_W-1:0] words [NUM_COEF];
    foreach (words[i]) begin
      case ($urandom_range(0, 7))
        0:       words[i] = '0;
        1:       words[i] = '1;
        default: words[i] = COEF_W'($urandom_range(0, 65535));
      endcase
    end
    c = '{words[0], words[1], words[2], words[3], words[4], words[5]};
    return c;
  endfunction

  // Pressure with the reset delta, first with zero coefficients and then with real ones.
  task automatic test_pressure_before_temperature();
    send_conversion(KIND_PRES, 24'h8A_3C21);
    drain();
    program_cal('{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312});
    send_conversion(KIND_PRES, 24'h8A_3C21);
    send_conversion(KIND_TEMP, 24'd8077636);
    send_conversion(KIND_PRES, 24'd6465444);
    drain();
  endtask

  task automatic test_field_extremes();
    program_cal('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_conversion(KIND_TEMP, '0);
    send_conversion(KIND_PRES, RAW_MAX);
    send_conversion(KIND_PRES, '0);
    send_conversion(KIND_TEMP, RAW_MAX);
    send_conversion(KIND_PRES, RAW_MAX);
    send_conversion(KIND_PRES, '0);
    drain();
    program_cal('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
    send_conversion(KIND_TEMP, RAW_MAX);
    send_conversion(KIND_PRES, RAW_MAX);
    drain();
    program_cal('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_conversion(KIND_TEMP, RAW_MAX);
    send_conversion(KIND_PRES, RAW_MAX);
    drain();
  endtask

  // Writes beyond the six registers must leave the calibration words alone.
  task automatic test_spare_index();
    program_cal('{16'd1000, 16'd2000, 16'd3000, 16'd4000, 16'd5000, 16'd6000});
    write_spare(IDX_SPARE_LO, 16'hFFFF);
    write_spare(IDX_SPARE_HI, 16'h5A5A);
    send_conversion(KIND_TEMP, 24'h123456);
    send_conversion(KIND_PRES, 24'hABCDEF);
    drain();
  endtask

  // New coefficients after a temperature request do not recompute the kept delta.
  task automatic test_stale_delta();
    send_conversion(KIND_TEMP, 24'h00_0100);
    drain();
    program_cal('{16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000});
    send_conversion(KIND_PRES, 24'hFF_0000);
    send_conversion(KIND_PRES, 24'h00_FFFF);
    drain();
  endtask

  task automatic test_random_conversions();
    coef_t            c;
    kind_t            kind;
    logic [RAW_W-1:0] raw;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        1:       c = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
        default: c = rand_cal();
      endcase
      program_cal(c);
      sender_steady   = ($urandom_range(0, 3) == 0);
      receiver_steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Roughly three in ten requests are temperature, the rest pressure.
        kind = ($urandom_range(0, 9) < 3) ? KIND_TEMP : KIND_PRES;
        case ($urandom_range(0, 19))
          0:       raw = '0;
          1:       raw = RAW_MAX;
          default: raw = RAW_W'($urandom());
        endcase
        send_conversion(kind, raw);
      end
      drain();
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (receiver_steady) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      int pause;
      pause = pick_pause();
      out_ready  <= (pause == 0);
      stall_left <= (pause > 0) ? pause - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      reading_t exp_r;
      if (pending_readings.size() == 0) begin
        $error("result with no request outstanding: kind %0d", result_kind);
        mismatches++;
      end else begin
        exp_r = pending_readings.pop_front();
        if (result_kind !== exp_r.kind) begin
          $error("result_kind: expected %0d, got %0d", exp_r.kind, result_kind);
          mismatches++;
        end
        if (temperature !== exp_r.temp) begin
          $error("temperature: expected %0d, got %0d", exp_r.temp, temperature);
          mismatches++;
        end
        if (pressure !== exp_r.pres) begin
          $error("pressure: expected %0d, got %0d", exp_r.pres, pressure);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cal     = '0;
    kept_dt = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pressure_before_temperature();
    test_field_extremes();
    test_spare_index();
    test_stale_delta();
    test_random_conversions();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
